### design/srb_pkg.sv
// Shared types and constants for the sequence reorder buffer.
`timescale 1ns / 1ps
`default_nettype none
package srb_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_W    = 16;
    localparam int PAY_W   = 16;
    localparam int WANT_W  = 17;
    localparam int KIND_W  = 3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_INSERTED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DUPLICATE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DRAINED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] payload;
    } cell_data_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### design/srb_cell.sv
// One cell of the sorted chain: holds an entry, shifts right on insert, left on pop.
`timescale 1ns / 1ps
`default_nettype none
module srb_cell
    import srb_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [ID_W-1:0]  new_id,
    input  wire logic [PAY_W-1:0] new_payload,
    input  wire cell_data_t       prev_data,
    input  wire logic             prev_gt,
    input  wire cell_data_t       next_data,
    output cell_data_t            data,
    output logic                  gt,
    output logic                  dup
);

    cell_data_t data_reg;
    cell_data_t data_next;

    assign data = data_reg;
    assign gt   = !data_reg.valid || (data_reg.id > new_id);
    assign dup  = data_reg.valid && (data_reg.id == new_id);

    always_comb begin
        data_next = data_reg;
        if (ctrl.pop) begin
            data_next = next_data;
        end else if (ctrl.ins) begin
            if (prev_gt) begin
                data_next = prev_data;
            end else if (gt) begin
                data_next.valid   = 1'b1;
                data_next.id      = new_id;
                data_next.payload = new_payload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg.id      <= data_next.id;
        data_reg.payload <= data_next.payload;
        if (!aresetn) begin
            data_reg.valid <= 1'b0;
        end else begin
            data_reg.valid <= data_next.valid;
        end
    end

endmodule
`default_nettype wire

### design/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: cell chain, command control and result register.
// Usage:
//   The s_ channel carries commands. An insert (s_command 0) places s_msg_id and
//   s_payload_handle into a chain of DEPTH cells kept sorted by ascending id and
//   gives one result: inserted, duplicate dropped or full dropped. A drain
//   (s_command 1) pops entries from the head while each id is s_last_written
//   plus one, then the popped id plus one, giving one result per popped entry,
//   or a single "nothing drained" result when the head does not match.
//   m_last marks the final result of each command.
// Timing:
//   An insert is resolved at its accepting edge and its result is on the m_
//   channel the next cycle; with m_ready high inserts sustain one per cycle.
//   A drain is accepted into the drain state, which then takes each result from the
//   head cell, or gives the nothing-drained result, and holds while the result
//   register is not free; the chain shifts one place per popped entry.
// Reset:
//   aresetn (synchronous, active low) empties the chain at once; no clearing pass.
// Stalls:
//   While a result waits with m_ready low, the result register and the chain
//   hold and s_ready stays low.
`timescale 1ns / 1ps
`default_nettype none
module sequence_reorder_buffer
    import srb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic [ID_W-1:0]   s_msg_id,
    input  wire logic [PAY_W-1:0]  s_payload_handle,
    input  wire logic [WANT_W-1:0] s_last_written,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [KIND_W-1:0]      m_kind,
    output logic [ID_W-1:0]        m_out_id,
    output logic [PAY_W-1:0]       m_out_payload,
    output logic [WANT_W-1:0]      m_next_expected,
    output logic                   m_last
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic              state_reg, state_next;
    logic [WANT_W-1:0] want_reg, want_next;
    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [PAY_W-1:0]  pay_reg, pay_next;
    logic [WANT_W-1:0] nexp_reg, nexp_next;
    logic              last_reg, last_next;

    cell_data_t        cell_data [DEPTH];
    logic [DEPTH-1:0]  cell_gt;
    logic [DEPTH-1:0]  cell_dup;
    logic [DEPTH-1:0]  cell_valid;
    cell_ctrl_t        ctrl;

    logic              out_free;
    logic              accept;
    logic              any_dup;
    logic              full;
    logic              head_match;
    logic [WANT_W-1:0] head_plus;
    logic              run_ends;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            cell_data_t prev_d;
            cell_data_t next_d;
            logic       prev_g;
            if (g == 0) begin : g_head
                assign prev_d = '0;
                assign prev_g = 1'b0;
            end else begin : g_mid
                assign prev_d = cell_data[g-1];
                assign prev_g = cell_gt[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign next_d = '0;
            end else begin : g_body
                assign next_d = cell_data[g+1];
            end
            srb_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .new_id      (s_msg_id),
                .new_payload (s_payload_handle),
                .prev_data   (prev_d),
                .prev_gt     (prev_g),
                .next_data   (next_d),
                .data        (cell_data[g]),
                .gt          (cell_gt[g]),
                .dup         (cell_dup[g])
            );
            assign cell_valid[g] = cell_data[g].valid;
        end
    endgenerate

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && out_free;
    assign accept     = s_valid && s_ready;
    assign any_dup    = |cell_dup;
    assign full       = cell_valid[DEPTH-1];
    assign head_match = cell_data[0].valid && ({1'b0, cell_data[0].id} == want_reg);
    assign head_plus  = {1'b0, cell_data[0].id} + WANT_W'(1);
    assign run_ends   = !(cell_data[1].valid && ({1'b0, cell_data[1].id} == head_plus));

    always_comb begin
        state_next   = state_reg;
        want_next    = want_reg;
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        id_next      = id_reg;
        pay_next     = pay_reg;
        nexp_next    = nexp_reg;
        last_next    = last_reg;
        ctrl         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_INSERT) begin
                        m_valid_next = 1'b1;
                        id_next      = s_msg_id;
                        pay_next     = '0;
                        nexp_next    = '0;
                        last_next    = 1'b1;
                        if (any_dup) begin
                            kind_next = KIND_DUPLICATE;
                        end else if (full) begin
                            kind_next = KIND_FULL;
                        end else begin
                            kind_next = KIND_INSERTED;
                            ctrl.ins  = 1'b1;
                        end
                    end else begin
                        want_next  = s_last_written + WANT_W'(1);
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (head_match) begin
                        kind_next = KIND_DRAINED;
                        id_next   = cell_data[0].id;
                        pay_next  = cell_data[0].payload;
                        nexp_next = head_plus;
                        last_next = run_ends;
                        want_next = head_plus;
                        ctrl.pop  = 1'b1;
                        if (run_ends) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        kind_next  = KIND_EMPTY;
                        id_next    = '0;
                        pay_next   = '0;
                        nexp_next  = '0;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        want_reg <= want_next;
        kind_reg <= kind_next;
        id_reg   <= id_next;
        pay_reg  <= pay_next;
        nexp_reg <= nexp_next;
        last_reg <= last_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_out_id        = id_reg;
    assign m_out_payload   = pay_reg;
    assign m_next_expected = nexp_reg;
    assign m_last          = last_reg;

    a_chain_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
        else $error("occupied cells not contiguous from head");

    a_insert_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_command == CMD_INSERT) |=> m_valid && m_last)
        else $error("insert gave no single result");

    a_drain_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_DRAINED) |->
            m_next_expected == ({1'b0, m_out_id} + WANT_W'(1)))
        else $error("drained result carries wrong next id");

    a_busy_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> !s_ready)
        else $error("command taken during drain");

endmodule
`default_nettype wire

### verif/tb_sequence_reorder_buffer.sv
// Self-checking testbench for the sequence reorder buffer: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_sequence_reorder_buffer;
    import srb_pkg::*;

    localparam int TOTAL_ITEMS = 320;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [PAY_W-1:0]  payload;
        logic [WANT_W-1:0] next_exp;
        logic              last;
    } result_t;

    typedef struct {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [PAY_W-1:0]  pay;
        logic [WANT_W-1:0] lw;
        bit                typed;
        result_t           typed_res;
    } command_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_command = CMD_INSERT;
    logic [ID_W-1:0]   s_msg_id = '0;
    logic [PAY_W-1:0]  s_payload_handle = '0;
    logic [WANT_W-1:0] s_last_written = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [KIND_W-1:0] m_kind;
    logic [ID_W-1:0]   m_out_id;
    logic [PAY_W-1:0]  m_out_payload;
    logic [WANT_W-1:0] m_next_expected;
    logic              m_last;

    logic [ID_W-1:0]  held_ids[DEPTH];
    logic [PAY_W-1:0] held_pays[DEPTH];
    int               held_count = 0;
    result_t          step_out[DEPTH];
    int               drained_last_id;
    int               longest_run = 0;

    result_t owed_results[$];
    command_t directed_steps[$];

    int items_sent = 0;
    int insert_count = 0;
    int drain_count = 0;
    int checked = 0;
    int mismatches = 0;
    int kind_seen[5] = '{0, 0, 0, 0, 0};
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    sequence_reorder_buffer u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_msg_id        (s_msg_id),
        .s_payload_handle(s_payload_handle),
        .s_last_written  (s_last_written),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_out_id        (m_out_id),
        .m_out_payload   (m_out_payload),
        .m_next_expected (m_next_expected),
        .m_last          (m_last)
    );

    always #10 aclk = ~aclk;

    function automatic result_t res(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                    logic [PAY_W-1:0] pay, logic [WANT_W-1:0] nxt,
                                    logic last);
        return {kind, id, pay, nxt, last};
    endfunction

    function automatic command_t mk(logic cmd, logic [ID_W-1:0] id, logic [PAY_W-1:0] pay,
                                    logic [WANT_W-1:0] lw, bit typed,
                                    logic [KIND_W-1:0] kind);
        command_t c;
        c.cmd = cmd;
        c.id = id;
        c.pay = pay;
        c.lw = lw;
        c.typed = typed;
        c.typed_res = res(kind, (kind == KIND_EMPTY) ? '0 : id, '0, '0, 1'b1);
        return c;
    endfunction

    function automatic logic [WANT_W-1:0] rand_lw();
        if ($urandom_range(9) == 0)
            return '1;
        return WANT_W'($urandom_range(0, 65535));
    endfunction

    // Apply one command to the sorted table; results land in step_out.
    function automatic int reorder_apply(command_t c);
        int  i;
        int  pos;
        int  want;
        int  n;
        bit  dup;
        n = 0;
        dup = 0;
        if (c.cmd == CMD_INSERT) begin
            for (i = 0; i < held_count; i++)
                if (held_ids[i] == c.id)
                    dup = 1;
            if (dup) begin
                step_out[0] = res(KIND_DUPLICATE, c.id, '0, '0, 1'b1);
            end else if (held_count >= DEPTH) begin
                step_out[0] = res(KIND_FULL, c.id, '0, '0, 1'b1);
            end else begin
                pos = 0;
                while (pos < held_count && held_ids[pos] < c.id)
                    pos++;
                for (i = held_count; i > pos; i--) begin
                    held_ids[i] = held_ids[i-1];
                    held_pays[i] = held_pays[i-1];
                end
                held_ids[pos] = c.id;
                held_pays[pos] = c.pay;
                held_count++;
                step_out[0] = res(KIND_INSERTED, c.id, '0, '0, 1'b1);
            end
            return 1;
        end
        want = $signed(c.lw);
        want = want + 1;
        while (n < held_count && int'(held_ids[n]) == want) begin
            step_out[n] = res(KIND_DRAINED, held_ids[n], held_pays[n],
                              WANT_W'(want + 1), 1'b0);
            want++;
            n++;
        end
        if (n == 0) begin
            step_out[0] = res(KIND_EMPTY, '0, '0, '0, 1'b1);
            return 1;
        end
        step_out[n-1].last = 1'b1;
        for (i = 0; i + n < held_count; i++) begin
            held_ids[i] = held_ids[i+n];
            held_pays[i] = held_pays[i+n];
        end
        held_count -= n;
        drained_last_id = want - 1;
        if (n > longest_run)
            longest_run = n;
        return n;
    endfunction

    task automatic send(command_t c);
        int n;
        int i;
        if (items_sent < TOTAL_ITEMS / 3) begin
            tx_idle_pct = 23;
            rx_idle_pct = 53;
        end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
            tx_idle_pct = 53;
            rx_idle_pct = 23;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= c.cmd;
        s_msg_id <= c.id;
        s_payload_handle <= c.pay;
        s_last_written <= c.lw;
        do @(posedge aclk); while (!s_ready);
        n = reorder_apply(c);
        if (c.typed)
            owed_results.push_back(c.typed_res);
        else
            for (i = 0; i < n; i++)
                owed_results.push_back(step_out[i]);
        items_sent++;
        if (c.cmd == CMD_INSERT)
            insert_count++;
        else
            drain_count++;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_out_id, m_out_payload, m_next_expected, m_last};
                checked++;
                if (got.kind < 5)
                    kind_seen[got.kind]++;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("Unexpected result at %0t: kind %0d id %0d payload %0d next %0d last %0d",
                                 $realtime, got.kind, got.id, got.payload, got.next_exp, got.last);
                end else begin
                    want = owed_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"Mismatch at %0t (expected/actual): kind %0d/%0d id %0d/%0d ",
                                      "payload %0d/%0d next %0d/%0d last %0d/%0d"}, $realtime,
                                     want.kind, got.kind, want.id, got.id, want.payload,
                                     got.payload, want.next_exp, got.next_exp, want.last, got.last);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int i;
        int j;
        int k;
        int tmp;
        int base;
        int resume;
        int mid;
        int choice;
        int delivered;
        int order[16];
        logic [ID_W-1:0] nid;

        // Fill the table out of order, hit duplicate-over-full, drain the longest run.
        directed_steps.push_back(mk(CMD_DRAIN, 16'hFFFF, 16'hFFFF, '1, 1, KIND_EMPTY));
        directed_steps.push_back(mk(CMD_INSERT, 16'd0, 16'hFFFF, '1, 1, KIND_INSERTED));
        directed_steps.push_back(mk(CMD_INSERT, 16'd2, 16'hAAAA, '0, 1, KIND_INSERTED));
        directed_steps.push_back(mk(CMD_INSERT, 16'd1, 16'h5555, '0, 1, KIND_INSERTED));
        for (i = 15; i >= 3; i--)
            directed_steps.push_back(mk(CMD_INSERT, ID_W'(i), PAY_W'(i * 16'h1111), '0, 1,
                                        KIND_INSERTED));
        directed_steps.push_back(mk(CMD_INSERT, 16'd0, 16'h1234, '0, 1, KIND_DUPLICATE));
        directed_steps.push_back(mk(CMD_INSERT, 16'd500, 16'h0001, '0, 1, KIND_FULL));
        directed_steps.push_back(mk(CMD_DRAIN, 16'd0, 16'd0, '1, 0, KIND_DRAINED));
        directed_steps.push_back(mk(CMD_INSERT, 16'hFFFF, 16'h0000, '1, 1, KIND_INSERTED));
        directed_steps.push_back(mk(CMD_DRAIN, 16'd0, 16'd0, 17'd65534, 0, KIND_DRAINED));
        directed_steps.push_back(mk(CMD_DRAIN, 16'hFFFF, 16'hFFFF, 17'd7, 1, KIND_EMPTY));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i])
            send(directed_steps[i]);

        delivered = -1;
        while (items_sent < TOTAL_ITEMS) begin
            choice = $urandom_range(99);
            if (choice < 70) begin
                // in-order window inserted shuffled, then drained from its start
                if ($urandom_range(99) < 60 && delivered < 65500)
                    base = delivered;
                else if ($urandom_range(19) == 0)
                    base = -1;
                else if ($urandom_range(9) == 0)
                    base = $urandom_range(65520, 65535);
                else
                    base = $urandom_range(0, 65500);
                k = ($urandom_range(3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
                for (i = 0; i < k; i++)
                    order[i] = i + 1;
                for (i = k - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                mid = ($urandom_range(2) == 0) ? $urandom_range(1, k) : k;
                resume = base;
                for (i = 0; i < k; i++) begin
                    nid = ID_W'(base + order[i]);
                    send(mk(CMD_INSERT, nid, PAY_W'($urandom), rand_lw(), 0, KIND_INSERTED));
                    if ($urandom_range(9) == 0)
                        send(mk(CMD_INSERT, nid, PAY_W'($urandom), rand_lw(), 0,
                                KIND_INSERTED));
                    if (i + 1 == mid && mid < k) begin
                        send(mk(CMD_DRAIN, ID_W'($urandom), PAY_W'($urandom),
                                WANT_W'(resume), 0, KIND_DRAINED));
                        if (step_out[0].kind == KIND_DRAINED)
                            resume = drained_last_id;
                    end
                end
                send(mk(CMD_DRAIN, ID_W'($urandom), PAY_W'($urandom), WANT_W'(resume), 0,
                        KIND_DRAINED));
                if (step_out[0].kind == KIND_DRAINED)
                    resume = drained_last_id;
                delivered = resume;
            end else if (choice < 85) begin
                send(mk(CMD_INSERT, ID_W'($urandom), PAY_W'($urandom), rand_lw(), 0,
                        KIND_INSERTED));
            end else if (choice < 93 || held_count == 0) begin
                send(mk(CMD_DRAIN, ID_W'($urandom), PAY_W'($urandom), rand_lw(), 0,
                        KIND_DRAINED));
            end else begin
                // clear stray entries from the head
                send(mk(CMD_DRAIN, ID_W'($urandom), PAY_W'($urandom),
                        WANT_W'(int'(held_ids[0]) - 1), 0, KIND_DRAINED));
            end
        end
        s_valid <= 1'b0;

        while (owed_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d commands (%0d inserts, %0d drains), checked %0d results.",
                 items_sent, insert_count, drain_count, checked);
        $display("Seen: %0d inserted, %0d duplicate, %0d full, %0d drained, %0d empty; longest run %0d.",
                 kind_seen[KIND_INSERTED], kind_seen[KIND_DUPLICATE], kind_seen[KIND_FULL],
                 kind_seen[KIND_DRAINED], kind_seen[KIND_EMPTY], longest_run);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
